>>> hdl/gpio_pad_direction_control_assert.svh
// Assertion macros for the pad direction control block.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef GPIO_PAD_DIRECTION_CONTROL_ASSERT_SVH
`define GPIO_PAD_DIRECTION_CONTROL_ASSERT_SVH

// Same-cycle implication.
`define GPDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication.
`define GPDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> hdl/gpdc_pkg.sv
// Shared types and constants of the pad direction control block.
// No dependencies.
`timescale 1ns / 1ps

package gpdc_pkg;

  localparam int NumPortsDef = 4;
  localparam int PortW       = 2;
  localparam int BitW        = 3;
  localparam int ByteW       = 8;
  localparam int PinW        = PortW + BitW;

  localparam logic [ByteW-1:0] LatchReset = 8'hFF;
  localparam logic [ByteW-1:0] AnalogOn   = 8'h01;

  typedef enum logic [2:0] {
    OP_DIR    = 3'd0,
    OP_OD     = 3'd1,
    OP_PULLUP = 3'd2,
    OP_LATCH  = 3'd3,
    OP_ANALOG = 3'd4,
    OP_QUERY  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ACT_LOW     = 2'd0,
    ACT_HIGH    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_QUERY   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_QUERY = 2'd1,
    ST_SCAN  = 2'd2
  } state_e;

  typedef struct packed {
    logic accept;
    logic load_query;
    logic load_pad;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_query;
    logic start_scan;
    logic emit_now;
    logic cnt_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> hdl/gpdc_ctrl.sv
// Sequencer of the pad direction control block.
// Depends on gpdc_pkg; drives commands into gpdc_dp.
`timescale 1ns / 1ps

module gpdc_ctrl
  import gpdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.start_query) begin
            state_d = ST_QUERY;
          end else if (sts_i.start_scan) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_QUERY: begin
        if (sts_i.out_free) begin
          cmd_o.load_query = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // skip silent bits, hold an emitting bit until the output frees up
        if (!sts_i.emit_now) begin
          cmd_o.advance = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.load_pad = 1'b1;
          cmd_o.advance  = 1'b1;
        end
        if (cmd_o.advance && sts_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/gpdc_dp.sv
// Port registers, item latch, bit scan counter and output register.
// Depends on gpdc_pkg; controlled by gpdc_ctrl.
`timescale 1ns / 1ps

module gpdc_dp
  import gpdc_pkg::*;
#(
  parameter int NUM_PORTS = NumPortsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       in_operation_i,
  input  logic [PortW-1:0] in_port_i,
  input  logic [BitW-1:0]  in_pin_bit_i,
  input  logic [ByteW-1:0] in_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PinW-1:0]  out_pin_o,
  output logic [1:0]       out_action_o,
  output logic             out_drive_en_o,
  output logic             out_analog_sel_o,
  output logic             out_pullup_high_o,
  output logic             out_last_o,
  input  ctrl_cmd_t        cmd_i,
  output ctrl_sts_t        sts_o
);

  localparam int PortIdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic [ByteW-1:0] dir_q    [NUM_PORTS];
  logic [ByteW-1:0] od_q     [NUM_PORTS];
  logic [ByteW-1:0] pu_q     [NUM_PORTS];
  logic [ByteW-1:0] latch_q  [NUM_PORTS];
  logic [ByteW-1:0] analog_q [NUM_PORTS];

  logic [PortIdxW+PortW-1:0] port_ext;
  logic [PortIdxW-1:0]       idx;
  logic                      port_ok;
  op_e                       op;
  logic [ByteW-1:0]          chg;

  logic [PortW-1:0]    port_q;
  logic [PortIdxW-1:0] idx_q;
  logic                port_ok_q;
  logic [BitW-1:0]     bit_q;
  logic [ByteW-1:0]    val_q;
  logic [ByteW-1:0]    chg_q;
  logic [BitW-1:0]     cnt_q;

  logic [ByteW-1:0] emit_mask;
  logic [ByteW-1:0] later;
  action_e          pad_act;
  logic             q_dir, q_md, q_an, q_pu;

  logic             out_valid_q;
  logic [PinW-1:0]  out_pin_q;
  action_e          out_action_q;
  logic             out_md_q, out_an_q, out_pu_q, out_last_q;

  assign port_ext = {{PortIdxW{1'b0}}, in_port_i};
  assign idx      = port_ext[PortIdxW-1:0];
  assign port_ok  = (32'(in_port_i) < NUM_PORTS);
  assign op       = op_e'(in_operation_i);
  assign chg      = dir_q[idx] ^ in_value_i;

  assign sts_o.start_query = (op == OP_QUERY);
  assign sts_o.start_scan  = (op == OP_DIR) && port_ok && (chg != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        dir_q[p]    <= '0;
        od_q[p]     <= '0;
        pu_q[p]     <= '0;
        latch_q[p]  <= LatchReset;
        analog_q[p] <= '0;
      end
    end else if (cmd_i.accept && port_ok) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        if (idx == PortIdxW'(p)) begin
          unique case (op)
            OP_DIR:    dir_q[p]   <= in_value_i;
            OP_OD:     od_q[p]    <= in_value_i;
            OP_PULLUP: pu_q[p]    <= in_value_i;
            OP_LATCH:  latch_q[p] <= in_value_i;
            OP_ANALOG: analog_q[p][in_pin_bit_i] <= (in_value_i == AnalogOn);
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      port_q    <= in_port_i;
      idx_q     <= idx;
      port_ok_q <= port_ok;
      bit_q     <= in_pin_bit_i;
      val_q     <= in_value_i;
      chg_q     <= chg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.accept) begin
      cnt_q <= '0;
    end else if (cmd_i.advance) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // analog pins switched to output stay silent
  assign emit_mask      = chg_q & ~(val_q & analog_q[idx_q]);
  assign later          = emit_mask >> cnt_q;
  assign sts_o.emit_now = emit_mask[cnt_q];
  assign sts_o.cnt_last = &cnt_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (!val_q[cnt_q]) begin
      pad_act = ACT_RELEASE;
    end else if (!latch_q[idx_q][cnt_q]) begin
      pad_act = ACT_LOW;
    end else if (od_q[idx_q][cnt_q]) begin
      pad_act = ACT_RELEASE;
    end else begin
      pad_act = ACT_HIGH;
    end
  end

  assign q_dir = dir_q[idx_q][bit_q];
  assign q_md  = !port_ok_q || (q_dir && !(od_q[idx_q][bit_q] && val_q[0]));
  assign q_an  = port_ok_q && analog_q[idx_q][bit_q];
  assign q_pu  = port_ok_q && !q_dir && pu_q[idx_q][bit_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_query || cmd_i.load_pad) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      out_pin_q    <= {port_q, bit_q};
      out_action_q <= ACT_QUERY;
      out_md_q     <= q_md;
      out_an_q     <= q_an;
      out_pu_q     <= q_pu;
      out_last_q   <= 1'b1;
    end else if (cmd_i.load_pad) begin
      out_pin_q    <= {port_q, cnt_q};
      out_action_q <= pad_act;
      out_md_q     <= 1'b0;
      out_an_q     <= 1'b0;
      out_pu_q     <= 1'b0;
      out_last_q   <= (later[ByteW-1:1] == '0);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_pin_o         = out_pin_q;
  assign out_action_o      = out_action_q;
  assign out_drive_en_o    = out_md_q;
  assign out_analog_sel_o  = out_an_q;
  assign out_pullup_high_o = out_pu_q;
  assign out_last_o        = out_last_q;

endmodule

>>> hdl/gpio_pad_direction_control.sv
// Register writes are registered at acceptance; a query answer goes via the ST_QUERY state to the
// output register, input reopens once it is loaded; a pin-flipping direction write scans 8 pins.
// Throughput is set by the bit scan counter: one pin action per cycle at most, plus output stalls.
// Reset (rst_ni low, asynchronous): all pins input, open-drain and pull-up off, latches all
// ones, all pins digital, output empty.
// Top level; depends on gpdc_pkg, gpdc_ctrl and gpdc_dp.
`timescale 1ns / 1ps
`include "gpio_pad_direction_control_assert.svh"

module gpio_pad_direction_control
  import gpdc_pkg::*;
#(
  parameter int NUM_PORTS = NumPortsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       in_operation_i,
  input  logic [PortW-1:0] in_port_i,
  input  logic [BitW-1:0]  in_pin_bit_i,
  input  logic [ByteW-1:0] in_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PinW-1:0]  out_pin_o,
  output logic [1:0]       out_action_o,
  output logic             out_drive_en_o,
  output logic             out_analog_sel_o,
  output logic             out_pullup_high_o,
  output logic             out_last_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  gpdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gpdc_dp #(
    .NUM_PORTS (NUM_PORTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_operation_i    (in_operation_i),
    .in_port_i         (in_port_i),
    .in_pin_bit_i      (in_pin_bit_i),
    .in_value_i        (in_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_pin_o         (out_pin_o),
    .out_action_o      (out_action_o),
    .out_drive_en_o    (out_drive_en_o),
    .out_analog_sel_o  (out_analog_sel_o),
    .out_pullup_high_o (out_pullup_high_o),
    .out_last_o        (out_last_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

  `GPDC_ASSERT_IMP(a_no_load_idle, !in_stall_o, !(cmd.load_pad || cmd.load_query))
  `GPDC_ASSERT_IMP(a_pad_emits, cmd.load_pad, sts.emit_now && sts.out_free)
  `GPDC_ASSERT_IMP(a_query_last, out_valid_o && (out_action_o == ACT_QUERY), out_last_o)
  `GPDC_ASSERT_NXT(a_load_shows, cmd.load_pad || cmd.load_query, out_valid_o)

endmodule

>>> dv/tb_gpio_pad_direction_control.sv
// Testbench for gpio_pad_direction_control: random and directed register writes and pin
// queries, with pad actions checked beat by beat against a predictor class.
// Depends on gpdc_pkg and the block's RTL.
`timescale 1ns / 1ps

class pad_action_tracker;

  typedef struct {
    logic [gpdc_pkg::PinW-1:0] pin;
    gpdc_pkg::action_e         action;
    bit                        drive_en;
    bit                        analog_sel;
    bit                        pullup_high;
    bit                        last;
  } pad_event_t;

  logic [gpdc_pkg::ByteW-1:0] dir_q    [gpdc_pkg::NumPortsDef];
  logic [gpdc_pkg::ByteW-1:0] od_q     [gpdc_pkg::NumPortsDef];
  logic [gpdc_pkg::ByteW-1:0] pu_q     [gpdc_pkg::NumPortsDef];
  logic [gpdc_pkg::ByteW-1:0] latch_q  [gpdc_pkg::NumPortsDef];
  logic [gpdc_pkg::ByteW-1:0] analog_q [gpdc_pkg::NumPortsDef];
  pad_event_t                 waiting  [$];
  int                         fails;

  function new();
    for (int p = 0; p < gpdc_pkg::NumPortsDef; p++) begin
      dir_q[p]    = '0;
      od_q[p]     = '0;
      pu_q[p]     = '0;
      latch_q[p]  = gpdc_pkg::LatchReset;
      analog_q[p] = '0;
    end
    fails = 0;
  endfunction

  function pad_event_t make_event(logic [gpdc_pkg::PinW-1:0] pin, gpdc_pkg::action_e action);
    pad_event_t ev;
    ev.pin         = pin;
    ev.action      = action;
    ev.drive_en    = 1'b0;
    ev.analog_sel  = 1'b0;
    ev.pullup_high = 1'b0;
    ev.last        = 1'b0;
    return ev;
  endfunction

  function void note_request(logic [2:0] op, logic [gpdc_pkg::PortW-1:0] port,
                             logic [gpdc_pkg::BitW-1:0] bit_sel,
                             logic [gpdc_pkg::ByteW-1:0] value);
    pad_event_t                 ev;
    pad_event_t                 scan [$];
    logic [gpdc_pkg::ByteW-1:0] flipped;
    if (op == gpdc_pkg::OP_QUERY) begin
      ev = make_event({port, bit_sel}, gpdc_pkg::ACT_QUERY);
      ev.drive_en = 1'b1;
      ev.last     = 1'b1;
      if (port < gpdc_pkg::NumPortsDef) begin
        ev.analog_sel  = analog_q[port][bit_sel];
        ev.drive_en    = dir_q[port][bit_sel] && !(od_q[port][bit_sel] && value[0]);
        ev.pullup_high = !dir_q[port][bit_sel] && pu_q[port][bit_sel];
      end
      waiting.push_back(ev);
    end else if (port < gpdc_pkg::NumPortsDef) begin
      case (op)
        gpdc_pkg::OP_DIR: begin
          flipped     = dir_q[port] ^ value;
          dir_q[port] = value;
          for (int i = 0; i < gpdc_pkg::ByteW; i++) begin
            if (flipped[i]) begin
              if (!value[i]) begin
                scan.push_back(make_event({port, 3'(i)}, gpdc_pkg::ACT_RELEASE));
              end else if (!analog_q[port][i]) begin
                if (!latch_q[port][i]) begin
                  scan.push_back(make_event({port, 3'(i)}, gpdc_pkg::ACT_LOW));
                end else if (od_q[port][i]) begin
                  scan.push_back(make_event({port, 3'(i)}, gpdc_pkg::ACT_RELEASE));
                end else begin
                  scan.push_back(make_event({port, 3'(i)}, gpdc_pkg::ACT_HIGH));
                end
              end
            end
          end
          if (scan.size() > 0) scan[scan.size()-1].last = 1'b1;
          foreach (scan[k]) waiting.push_back(scan[k]);
        end
        gpdc_pkg::OP_OD:     od_q[port] = value;
        gpdc_pkg::OP_PULLUP: pu_q[port] = value;
        gpdc_pkg::OP_LATCH:  latch_q[port] = value;
        gpdc_pkg::OP_ANALOG: analog_q[port][bit_sel] = (value == gpdc_pkg::AnalogOn);
        default: ;
      endcase
    end
  endfunction

  function void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endfunction

  function void check_action(logic [gpdc_pkg::PinW-1:0] pin, logic [1:0] action,
                             logic drive_en, logic analog_sel, logic pullup_high,
                             logic last);
    pad_event_t want;
    if (waiting.size() == 0) begin
      $error("unexpected beat: pin %0d action %0d", pin, action);
      fails++;
      return;
    end
    want = waiting.pop_front();
    check_field("pin", 8'(want.pin), 8'(pin));
    check_field("action", 8'(want.action), 8'(action));
    check_field("drive_en", 8'(want.drive_en), 8'(drive_en));
    check_field("analog_sel", 8'(want.analog_sel), 8'(analog_sel));
    check_field("pullup_high", 8'(want.pullup_high), 8'(pullup_high));
    check_field("last", 8'(want.last), 8'(last));
  endfunction

endclass

module tb_gpio_pad_direction_control
  import gpdc_pkg::*;
();

  localparam logic [2:0] OpSpare6   = 3'd6;
  localparam logic [2:0] OpSpare7   = 3'd7;
  localparam int         CycleLimit = 200000;

  logic             clk_i             = 1'b0;
  logic             rst_ni            = 1'b0;
  logic             in_valid_i        = 1'b0;
  logic             in_stall_o;
  logic [2:0]       in_operation_i    = '0;
  logic [PortW-1:0] in_port_i         = '0;
  logic [BitW-1:0]  in_pin_bit_i      = '0;
  logic [ByteW-1:0] in_value_i        = '0;
  logic             out_valid_o;
  logic             out_stall_i       = 1'b0;
  logic [PinW-1:0]  out_pin_o;
  logic [1:0]       out_action_o;
  logic             out_drive_en_o;
  logic             out_analog_sel_o;
  logic             out_pullup_high_o;
  logic             out_last_o;

  pad_action_tracker tracker = new();

  bit idle_on        = 1'b1;
  int rx_left        = 0;
  int rx_hold_cycles = 0;
  int cycle_count    = 0;

  gpio_pad_direction_control i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_operation_i    (in_operation_i),
    .in_port_i         (in_port_i),
    .in_pin_bit_i      (in_pin_bit_i),
    .in_value_i        (in_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_pin_o         (out_pin_o),
    .out_action_o      (out_action_o),
    .out_drive_en_o    (out_drive_en_o),
    .out_analog_sel_o  (out_analog_sel_o),
    .out_pullup_high_o (out_pullup_high_o),
    .out_last_o        (out_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: short random stalls, or a long hold when requested
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_left        = rx_hold_cycles;
      rx_hold_cycles = 0;
    end
    if (rx_left > 0) begin
      out_stall_i <= 1'b1;
      rx_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      rx_left = $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_action(out_pin_o, out_action_o, out_drive_en_o, out_analog_sel_o,
                           out_pullup_high_o, out_last_o);
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      tracker.note_request(in_operation_i, in_port_i, in_pin_bit_i, in_value_i);
    end
  end

  task automatic put_beat(logic [2:0] op, logic [PortW-1:0] port, logic [BitW-1:0] bit_sel,
                          logic [ByteW-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_operation_i <= op;
    in_port_i      <= port;
    in_pin_bit_i   <= bit_sel;
    in_value_i     <= value;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    int               done;
    int               pick;
    logic [2:0]       op;
    logic [ByteW-1:0] value;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = OP_DIR;
      else if (pick < 55) op = OP_QUERY;
      else if (pick < 65) op = OP_OD;
      else if (pick < 75) op = OP_PULLUP;
      else if (pick < 85) op = OP_LATCH;
      else if (pick < 96) op = OP_ANALOG;
      else if (pick < 98) op = OpSpare6;
      else                op = OpSpare7;
      case ($urandom_range(0, 7))
        0:       value = 8'h00;
        1:       value = 8'hFF;
        default: value = ByteW'($urandom_range(0, 255));
      endcase
      if (op == OP_ANALOG && $urandom_range(0, 1) == 1) value = AnalogOn;
      put_beat(op, PortW'($urandom_range(0, 3)), BitW'($urandom_range(0, 7)), value);
      if (op != OpSpare6 && op != OpSpare7) done++;
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    put_beat(OP_QUERY, 0, 0, 8'h00);
    put_beat(OP_PULLUP, 1, 0, 8'hFF);
    put_beat(OP_QUERY, 1, 7, 8'h01);
    put_beat(OP_LATCH, 0, 0, 8'h0F);
    put_beat(OP_OD, 0, 0, 8'h05);
    put_beat(OP_ANALOG, 0, 1, AnalogOn);
    put_beat(OP_ANALOG, 0, 2, 8'h03);
    put_beat(OP_DIR, 0, 0, 8'hFF);
    put_beat(OP_DIR, 0, 0, 8'hFF);
    put_beat(OP_QUERY, 0, 0, 8'h01);
    put_beat(OP_QUERY, 0, 0, 8'hFE);
    put_beat(OP_QUERY, 0, 1, 8'h00);
    put_beat(OP_QUERY, 0, 3, 8'hFF);
    put_beat(OP_DIR, 0, 0, 8'h00);
    put_beat(OP_LATCH, 3, 0, 8'h00);
    put_beat(OP_DIR, 3, 0, 8'h80);
    put_beat(OP_QUERY, 3, 7, 8'hFF);
    put_beat(OpSpare6, 2, 5, 8'hFF);
    put_beat(OpSpare7, 1, 3, 8'h00);
    put_beat(OP_ANALOG, 2, 7, AnalogOn);
    put_beat(OP_DIR, 2, 7, 8'hFF);
    put_beat(OP_ANALOG, 2, 7, 8'h00);
    put_beat(OP_QUERY, 2, 7, 8'h00);
    put_beat(OP_DIR, 1, 0, 8'h55);

    send_random(180);

    // hold the output while beats keep coming so the block backs up
    @(posedge clk_i);
    rx_hold_cycles = 150;
    idle_on = 1'b0;
    @(negedge clk_i);
    send_random(30);
    idle_on = 1'b1;

    send_random(110);
    idle_on = 1'b0;
    send_random(80);
    in_valid_i <= 1'b0;

    while (tracker.waiting.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
